### src/dll_pkg.sv
// Package: sizes, request codes and link-node types for the linked list engine.
`timescale 1ns / 1ps
`default_nettype none
package dll_pkg;
  localparam int NodeCount  = 64;
  localparam int ValueWidth = 64;
  localparam int IdxW       = $clog2(NodeCount);
  localparam int PtrW       = IdxW + 1;
  localparam int CntW       = 7;
  localparam logic [PtrW-1:0] Nil = PtrW'(NodeCount);
  localparam int LinkW      = 2 * PtrW;

  localparam logic [4:0] ReqClear     = 5'd0;
  localparam logic [4:0] ReqInsHead   = 5'd1;
  localparam logic [4:0] ReqInsTail   = 5'd2;
  localparam logic [4:0] ReqCurHead   = 5'd3;
  localparam logic [4:0] ReqCurTail   = 5'd4;
  localparam logic [4:0] ReqGetHead   = 5'd5;
  localparam logic [4:0] ReqGetTail   = 5'd6;
  localparam logic [4:0] ReqDelHead   = 5'd7;
  localparam logic [4:0] ReqDelTail   = 5'd8;
  localparam logic [4:0] ReqDelAfter  = 5'd9;
  localparam logic [4:0] ReqDelBefore = 5'd10;
  localparam logic [4:0] ReqInsAfter  = 5'd11;
  localparam logic [4:0] ReqInsBefore = 5'd12;
  localparam logic [4:0] ReqGetCur    = 5'd13;
  localparam logic [4:0] ReqSetCur    = 5'd14;
  localparam logic [4:0] ReqNext      = 5'd15;
  localparam logic [4:0] ReqPrev      = 5'd16;
  localparam logic [4:0] ReqQuery     = 5'd17;

  // one entry of the link memory
  typedef struct packed {
    logic [PtrW-1:0] prv;
    logic [PtrW-1:0] nxt;
  } link_t;

  // result item
  typedef struct packed {
    logic [63:0]     read_value;
    logic            read_valid;
    logic            error;
    logic            cursor_active;
    logic [CntW-1:0] length;
  } result_t;
endpackage
`default_nettype wire

### src/dll_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module dll_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### src/dll_alloc.sv
// Free-node map with a lowest-free-index search.
`timescale 1ns / 1ps
`default_nettype none
module dll_alloc (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         clear_i,
  input  wire logic                         take_i,
  input  wire logic                         give_i,
  input  wire logic [dll_pkg::IdxW-1:0]     give_idx_i,
  output logic                              avail_o,
  output logic      [dll_pkg::IdxW-1:0]     free_idx_o
);
  import dll_pkg::*;

  logic [NodeCount-1:0] free_q, free_d;

  // priority search for the lowest free node
  always_comb begin
    avail_o    = 1'b0;
    free_idx_o = '0;
    for (int i = NodeCount - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        avail_o    = 1'b1;
        free_idx_o = IdxW'(i);
      end
    end
  end

  always_comb begin
    free_d = free_q;
    if (clear_i) begin
      free_d = '1;
    end else begin
      if (take_i) free_d[free_idx_o] = 1'b0;
      if (give_i) free_d[give_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q <= '1;
    end else begin
      free_q <= free_d;
    end
  end
endmodule
`default_nettype wire

### src/doubly_linked_list_with_cursor.sv
// Top level: linked list engine with head, tail and cursor over a node pool.
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_valid_i / req_stall_o | req_type_i, value_i
//  rsp     | out | rsp_valid_o / rsp_stall_i | read_value, read_valid, error, cursor_active, length
//
// Each item reads its start node (cursor, head or tail) from the link and value
// memories: accept plus execute for reads, moves, set and no-ops. Inserts and
// head/tail deletes add the states read a, patch a, patch b; delete after/before
// first reads the victim's links before those states.
// One item in flight: the input stalls until the result leaves, and the next
// item can be taken in the cycle the result is accepted. Reset empties the list.
`timescale 1ns / 1ps
`default_nettype none
module doubly_linked_list_with_cursor (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_stall_o,
  input  wire logic [4:0]  req_type_i,
  input  wire logic [63:0] value_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_stall_i,
  output logic [63:0]      read_value_o,
  output logic             read_valid_o,
  output logic             error_o,
  output logic             cursor_active_o,
  output logic [6:0]       length_o
);
  import dll_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StExe  = 6'b000010,
    StRdP  = 6'b000100,
    StRdA  = 6'b001000,
    StWrA  = 6'b010000,
    StWrB  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [4:0]            req_q;
  logic [ValueWidth-1:0] val_q;
  logic [PtrW-1:0]       head_q, head_d, tail_q, tail_d, cur_q, cur_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  // target node p and its neighbors a (prev) and b (next)
  logic [PtrW-1:0]       p_q, p_d, a_q, a_d, b_q, b_d;
  logic                  err_q, err_d;
  logic                  rv_q, rv_d;
  logic [63:0]           rd_q, rd_d;
  logic                  out_valid_q, out_valid_d;

  // memory ports
  logic                  lk_we, vl_we;
  logic [IdxW-1:0]       lk_waddr, vl_waddr, lk_raddr;
  link_t                 lk_wdata, lk_rdata;
  logic [ValueWidth-1:0] vl_wdata, vl_rdata;

  logic                  al_take, al_give, al_avail, al_clear;
  logic [IdxW-1:0]       al_idx;

  logic                  accept;
  logic                  is_ins;
  logic [63:0]           widened;
  logic [PtrW-1:0]       victim;

  function automatic logic is_node(logic [PtrW-1:0] p);
    return p < Nil;
  endfunction

  dll_ram #(.Width(LinkW), .Depth(NodeCount)) u_link (
    .clk_i, .we_i(lk_we), .waddr_i(lk_waddr), .wdata_i(lk_wdata),
    .raddr_i(lk_raddr), .rdata_o(lk_rdata)
  );
  dll_ram #(.Width(ValueWidth), .Depth(NodeCount)) u_value (
    .clk_i, .we_i(vl_we), .waddr_i(vl_waddr), .wdata_i(vl_wdata),
    .raddr_i(lk_raddr), .rdata_o(vl_rdata)
  );
  dll_alloc u_alloc (
    .clk_i, .rst_ni, .clear_i(al_clear), .take_i(al_take), .give_i(al_give),
    .give_idx_i(p_q[IdxW-1:0]), .avail_o(al_avail), .free_idx_o(al_idx)
  );

  assign req_stall_o = (state_q != StIdle) || (out_valid_q && rsp_stall_i);
  assign accept      = req_valid_i && !req_stall_o;
  assign is_ins = (req_q == ReqInsHead) || (req_q == ReqInsTail) ||
                  (req_q == ReqInsAfter) || (req_q == ReqInsBefore);
  assign widened = 64'($signed(vl_rdata));
  assign victim  = (req_q == ReqDelAfter) ? lk_rdata.nxt : lk_rdata.prv;

  // sequencer
  always_comb begin
    state_d = state_q;
    head_d = head_q; tail_d = tail_q; cur_d = cur_q; cnt_d = cnt_q;
    p_d = p_q; a_d = a_q; b_d = b_q;
    err_d = err_q; rv_d = rv_q; rd_d = rd_q;
    out_valid_d = out_valid_q && rsp_stall_i;
    lk_we = 1'b0; lk_waddr = p_q[IdxW-1:0]; lk_wdata = '0;
    vl_we = 1'b0; vl_waddr = p_q[IdxW-1:0]; vl_wdata = val_q;
    lk_raddr = cur_q[IdxW-1:0];
    al_take = 1'b0; al_give = 1'b0; al_clear = 1'b0;
    case (state_q)
      StIdle: begin
        // read the node the request starts from
        if (accept) begin
          case (req_type_i)
            ReqGetHead, ReqDelHead: lk_raddr = head_q[IdxW-1:0];
            ReqGetTail, ReqDelTail: lk_raddr = tail_q[IdxW-1:0];
            default:                lk_raddr = cur_q[IdxW-1:0];
          endcase
          state_d = StExe;
        end
      end
      StExe: begin
        // start node's link and value are on the read ports
        err_d = 1'b0; rv_d = 1'b0; rd_d = '0;
        state_d = StIdle;
        out_valid_d = 1'b1;
        case (req_q)
          ReqClear: begin
            al_clear = 1'b1;
            head_d = Nil; tail_d = Nil; cur_d = Nil; cnt_d = '0;
          end
          ReqCurHead: cur_d = head_q;
          ReqCurTail: cur_d = tail_q;
          ReqGetHead: begin
            if (is_node(head_q)) begin rv_d = 1'b1; rd_d = widened; end
            else err_d = 1'b1;
          end
          ReqGetTail: begin
            if (is_node(tail_q)) begin rv_d = 1'b1; rd_d = widened; end
            else err_d = 1'b1;
          end
          ReqGetCur: begin
            if (is_node(cur_q)) begin rv_d = 1'b1; rd_d = widened; end
            else err_d = 1'b1;
          end
          ReqSetCur: begin
            if (is_node(cur_q)) begin
              vl_we = 1'b1; vl_waddr = cur_q[IdxW-1:0];
            end
          end
          ReqNext: if (is_node(cur_q)) cur_d = is_node(lk_rdata.nxt) ? lk_rdata.nxt : Nil;
          ReqPrev: if (is_node(cur_q)) cur_d = is_node(lk_rdata.prv) ? lk_rdata.prv : Nil;
          ReqInsHead, ReqInsTail, ReqInsAfter, ReqInsBefore: begin
            if ((req_q == ReqInsAfter || req_q == ReqInsBefore) && !is_node(cur_q)) begin
              // cursor inactive: nothing to do
            end else if (!al_avail) begin
              err_d = 1'b1;
            end else begin
              // new node p goes between a and b
              case (req_q)
                ReqInsHead:  begin a_d = Nil; b_d = head_q; end
                ReqInsTail:  begin a_d = tail_q; b_d = Nil; end
                ReqInsAfter: begin a_d = cur_q; b_d = lk_rdata.nxt; end
                default:     begin a_d = lk_rdata.prv; b_d = cur_q; end
              endcase
              p_d = {1'b0, al_idx};
              state_d = StRdA;
              out_valid_d = 1'b0;
            end
          end
          ReqDelHead, ReqDelTail: begin
            p_d = (req_q == ReqDelHead) ? head_q : tail_q;
            if (is_node(p_d)) begin
              a_d = lk_rdata.prv; b_d = lk_rdata.nxt;
              state_d = StRdA;
              out_valid_d = 1'b0;
            end
          end
          ReqDelAfter, ReqDelBefore: begin
            // fetch the victim's links next
            if (is_node(cur_q) && is_node(victim)) begin
              p_d = victim;
              lk_raddr = victim[IdxW-1:0];
              state_d = StRdP;
              out_valid_d = 1'b0;
            end
          end
          default: ;
        endcase
      end
      StRdP: begin
        a_d = lk_rdata.prv; b_d = lk_rdata.nxt;
        state_d = StRdA;
      end
      StRdA: begin
        // read a; insert writes the new node, delete frees p and may clear the cursor; both update head, tail and count
        lk_raddr = a_q[IdxW-1:0];
        if (is_ins) begin
          lk_we = 1'b1; lk_waddr = p_q[IdxW-1:0];
          lk_wdata.prv = a_q; lk_wdata.nxt = b_q;
          vl_we = 1'b1; vl_waddr = p_q[IdxW-1:0];
          al_take = 1'b1;
          cnt_d = cnt_q + CntW'(1);
          if (!is_node(a_q)) head_d = p_q;
          if (!is_node(b_q)) tail_d = p_q;
        end else begin
          al_give = 1'b1;
          cnt_d = cnt_q - CntW'(1);
          if (!is_node(a_q)) head_d = b_q;
          if (!is_node(b_q)) tail_d = a_q;
          if (cur_q == p_q) cur_d = Nil;
        end
        state_d = StWrA;
      end
      StWrA: begin
        // patch a.next, read b
        lk_raddr = b_q[IdxW-1:0];
        if (is_node(a_q)) begin
          lk_we = 1'b1; lk_waddr = a_q[IdxW-1:0];
          lk_wdata.prv = lk_rdata.prv;
          lk_wdata.nxt = is_ins ? p_q : b_q;
        end
        state_d = StWrB;
      end
      StWrB: begin
        // patch b.prev
        if (is_node(b_q)) begin
          lk_we = 1'b1; lk_waddr = b_q[IdxW-1:0];
          lk_wdata.prv = is_ins ? p_q : a_q;
          lk_wdata.nxt = lk_rdata.nxt;
        end
        state_d = StIdle;
        out_valid_d = 1'b1;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= Nil;
      tail_q      <= Nil;
      cur_q       <= Nil;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cur_q       <= cur_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      val_q <= value_i[ValueWidth-1:0];
    end
    p_q <= p_d; a_q <= a_d; b_q <= b_d;
    err_q <= err_d; rv_q <= rv_d; rd_q <= rd_d;
  end

  assign rsp_valid_o     = out_valid_q;
  assign read_value_o    = rd_q;
  assign read_valid_o    = rv_q;
  assign error_o         = err_q;
  assign cursor_active_o = is_node(cur_q);
  assign length_o        = cnt_q;
endmodule
`default_nettype wire

### bench/doubly_linked_list_with_cursor_tb.sv
// Testbench: random and directed list operations checked against a behavioral list model.
`timescale 1ns / 1ps
`default_nettype none

// Expected results of the list engine, kept in issue order
class list_scoreboard;
  dll_pkg::result_t pending_q[$];
  logic [63:0] node_val [dll_pkg::NodeCount];
  int unsigned node_nxt [dll_pkg::NodeCount];
  int unsigned node_prv [dll_pkg::NodeCount];
  bit node_free [dll_pkg::NodeCount];
  int unsigned head_idx, tail_idx, cur_idx, count;
  int mismatches;
  int checked;
  int reads_ok;
  int errors_seen;

  function new();
    mismatches = 0;
    checked = 0;
    reads_ok = 0;
    errors_seen = 0;
    empty_list();
  endfunction

  function void empty_list();
    foreach (node_free[i]) node_free[i] = 1'b1;
    head_idx = dll_pkg::NodeCount;
    tail_idx = dll_pkg::NodeCount;
    cur_idx = dll_pkg::NodeCount;
    count = 0;
  endfunction

  function bit valid_idx(int unsigned p);
    return p < dll_pkg::NodeCount;
  endfunction

  // splice a node between a and b; 0 when the pool is exhausted
  function bit splice_in(int unsigned a, int unsigned b, logic [63:0] v);
    int unsigned n;
    n = dll_pkg::NodeCount;
    for (int i = 0; i < dll_pkg::NodeCount; i++) begin
      if (node_free[i]) begin
        n = i;
        break;
      end
    end
    if (n == dll_pkg::NodeCount) return 1'b0;
    node_free[n] = 1'b0;
    node_val[n] = v;
    node_prv[n] = a;
    node_nxt[n] = b;
    count++;
    if (valid_idx(a)) node_nxt[a] = n;
    else head_idx = n;
    if (valid_idx(b)) node_prv[b] = n;
    else tail_idx = n;
    return 1'b1;
  endfunction

  function void splice_out(int unsigned p);
    int unsigned a, b;
    if (!valid_idx(p)) return;
    a = node_prv[p];
    b = node_nxt[p];
    if (valid_idx(a)) node_nxt[a] = b;
    else head_idx = b;
    if (valid_idx(b)) node_prv[b] = a;
    else tail_idx = a;
    if (cur_idx == p) cur_idx = dll_pkg::NodeCount;
    node_free[p] = 1'b1;
    if (count > 0) count--;
  endfunction

  // apply one accepted request and queue its result
  function void note_request(logic [4:0] op, logic [63:0] v);
    dll_pkg::result_t r;
    bit on;
    r = '0;
    on = valid_idx(cur_idx);
    case (op)
      dll_pkg::ReqClear: empty_list();
      dll_pkg::ReqInsHead: r.error = !splice_in(dll_pkg::NodeCount, head_idx, v);
      dll_pkg::ReqInsTail: r.error = !splice_in(tail_idx, dll_pkg::NodeCount, v);
      dll_pkg::ReqCurHead: cur_idx = head_idx;
      dll_pkg::ReqCurTail: cur_idx = tail_idx;
      dll_pkg::ReqGetHead: begin
        if (valid_idx(head_idx)) begin
          r.read_value = node_val[head_idx];
          r.read_valid = 1'b1;
        end else r.error = 1'b1;
      end
      dll_pkg::ReqGetTail: begin
        if (valid_idx(tail_idx)) begin
          r.read_value = node_val[tail_idx];
          r.read_valid = 1'b1;
        end else r.error = 1'b1;
      end
      dll_pkg::ReqDelHead: splice_out(head_idx);
      dll_pkg::ReqDelTail: splice_out(tail_idx);
      dll_pkg::ReqDelAfter: if (on) splice_out(node_nxt[cur_idx]);
      dll_pkg::ReqDelBefore: if (on) splice_out(node_prv[cur_idx]);
      dll_pkg::ReqInsAfter:
        if (on) r.error = !splice_in(cur_idx, node_nxt[cur_idx], v);
      dll_pkg::ReqInsBefore:
        if (on) r.error = !splice_in(node_prv[cur_idx], cur_idx, v);
      dll_pkg::ReqGetCur: begin
        if (on) begin
          r.read_value = node_val[cur_idx];
          r.read_valid = 1'b1;
        end else r.error = 1'b1;
      end
      dll_pkg::ReqSetCur: if (on) node_val[cur_idx] = v;
      dll_pkg::ReqNext: if (on) cur_idx = node_nxt[cur_idx];
      dll_pkg::ReqPrev: if (on) cur_idx = node_prv[cur_idx];
      default: ;
    endcase
    if (!valid_idx(cur_idx)) cur_idx = dll_pkg::NodeCount;
    r.cursor_active = valid_idx(cur_idx);
    r.length = count[6:0];
    pending_q.push_back(r);
  endfunction

  function void check_result(dll_pkg::result_t got);
    dll_pkg::result_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %p", got);
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (want.read_valid) reads_ok++;
    if (want.error) errors_seen++;
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at result %0d: expected val=%h rv=%b err=%b cur=%b len=%0d",
                 checked, want.read_value, want.read_valid, want.error,
                 want.cursor_active, want.length);
        $display("  got val=%h rv=%b err=%b cur=%b len=%0d",
                 got.read_value, got.read_valid, got.error, got.cursor_active,
                 got.length);
      end
    end
  endfunction
endclass

module doubly_linked_list_with_cursor_tb;
  import dll_pkg::*;

  localparam int CycleLimit = 100000;
  // request code outside the defined range
  localparam logic [4:0] ReqUnused = 5'd31;

  logic clk_i;
  logic rst_ni;
  logic req_valid_i;
  logic req_stall_o;
  logic [4:0] req_type_i;
  logic [63:0] value_i;
  logic rsp_valid_o;
  logic rsp_stall_i;
  logic [63:0] read_value_o;
  logic read_valid_o;
  logic error_o;
  logic cursor_active_o;
  logic [6:0] length_o;

  list_scoreboard sb;
  int idle_pct;
  int stall_pct;
  int hold_off;
  int cycles;
  int accepted;

  doubly_linked_list_with_cursor uut (
    .clk_i, .rst_ni, .req_valid_i, .req_stall_o, .req_type_i, .value_i,
    .rsp_valid_o, .rsp_stall_i, .read_value_o, .read_valid_o, .error_o,
    .cursor_active_o, .length_o
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp_stall_i <= 1'b1;
    end else begin
      rsp_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && !rsp_stall_i)
      sb.check_result({read_value_o, read_valid_o, error_o, cursor_active_o, length_o});
  end

  // offer one item and hold it until accepted
  task automatic send_item(logic [4:0] op, logic [63:0] v);
    if ($urandom_range(99) < idle_pct) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= op;
    value_i <= v;
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
    sb.note_request(op, v);
    accepted++;
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly well-formed ops, weighted to build and walk lists
  function automatic logic [4:0] rand_op(int fill_bias);
    int k;
    k = $urandom_range(99);
    if (k < 2) return ReqClear;
    if (k < 4) return 5'($urandom_range(18, 31));
    if (k < 4 + fill_bias) return ($urandom_range(1)) ? ReqInsTail : ReqInsAfter;
    return 5'($urandom_range(1, 17));
  endfunction

  task automatic run_random(int n, int fill_bias);
    for (int i = 0; i < n; i++) send_item(rand_op(fill_bias), rand_value());
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_type_i = ReqQuery;
    value_i = '0;
    rsp_stall_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    cycles = 0;
    accepted = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, cursor inactive, ends, bad op, value extremes
    send_item(ReqGetHead, '0);
    send_item(ReqGetTail, '0);
    send_item(ReqGetCur, '0);
    send_item(ReqDelHead, '0);
    send_item(ReqDelTail, '0);
    send_item(ReqCurHead, '0);
    send_item(ReqInsAfter, 64'h5);
    send_item(ReqNext, '0);
    send_item(ReqInsHead, 64'h8000_0000_0000_0000);
    send_item(ReqInsTail, 64'h7fff_ffff_ffff_ffff);
    send_item(ReqCurHead, '0);
    send_item(ReqDelBefore, '0);
    send_item(ReqInsAfter, '1);
    send_item(ReqInsBefore, 64'h1234);
    send_item(ReqSetCur, 64'haaaa_5555_aaaa_5555);
    send_item(ReqGetCur, '0);
    send_item(ReqCurTail, '0);
    send_item(ReqDelAfter, '0);
    send_item(ReqPrev, '0);
    send_item(ReqDelTail, '0);
    send_item(ReqGetTail, '0);
    send_item(ReqQuery, '0);
    send_item(ReqUnused, '1);
    send_item(ReqGetHead, '0);
    send_item(ReqClear, '0);

    // pool full: fill past 64 nodes
    for (int i = 0; i < 70; i++) send_item(ReqInsTail, rand_value());
    send_item(ReqCurTail, '0);
    send_item(ReqInsBefore, '0);
    send_item(ReqDelHead, '0);

    // idle and stall phases
    idle_pct = 0;  stall_pct = 0;  run_random(350, 20);
    idle_pct = 53; stall_pct = 0;  run_random(300, 30);
    idle_pct = 0;  stall_pct = 53; run_random(300, 10);
    idle_pct = 11; stall_pct = 11; run_random(300, 20);

    // long hold-off on the receiver while items keep coming
    idle_pct = 0;
    stall_pct = 0;
    hold_off = 300;
    run_random(100, 20);
    run_random(200, 15);

    req_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d items sent, %0d results checked (%0d reads, %0d error flags)",
             accepted, sb.checked, sb.reads_ok, sb.errors_seen);
    $display("covered empty-list, pool-full, cursor edge cases and idle/stall phases");
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
